### hw/rtl/assert_macros.svh
// Assertion macros used by the controller of the FFT core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### hw/rtl/fftr2_pkg.sv
// Package with types, constants and the twiddle table of the radix-2 FFT core.
`default_nettype none
package fftr2_pkg;

  localparam int POINTS        = 512;
  localparam int HALF_POINTS   = POINTS / 2;
  localparam int LOG_POINTS    = 9;
  localparam int SAMPLE_WIDTH  = 16;
  localparam int TWIDDLE_WIDTH = 18;
  localparam int DATA_WIDTH    = 26;
  localparam int ADDR_W        = LOG_POINTS;
  localparam int TW_ADDR_W     = LOG_POINTS - 1;
  localparam int STAGE_W       = 4;
  localparam int PROD_W        = DATA_WIDTH + TWIDDLE_WIDTH;
  localparam int SUM_W         = PROD_W + 1;
  localparam int VAL_W         = DATA_WIDTH + 4;
  localparam int TW_SHIFT      = TWIDDLE_WIDTH - 1;
  localparam longint unsigned PI_Q30 = 64'd3373259426;

  typedef logic [ADDR_W-1:0]                addr_t;
  typedef logic [TW_ADDR_W-1:0]             tw_addr_t;
  typedef logic signed [DATA_WIDTH-1:0]     data_t;
  typedef logic signed [TWIDDLE_WIDTH-1:0]  tw_t;
  typedef tw_t tw_arr_t [HALF_POINTS];

  typedef enum logic [1:0] {
    WR_LOAD = 2'd0,
    WR_A    = 2'd1,
    WR_B    = 2'd2
  } wr_sel_e;

  typedef struct packed {
    logic     wr_en;
    wr_sel_e  wr_sel;
    addr_t    wr_addr;
    addr_t    rd_addr_a;
    addr_t    rd_addr_b;
    tw_addr_t tw_idx;
    logic     mul_en;
    logic     add_en;
    logic     out_load;
    logic     out_empty;
    logic     inverse;
  } cmd_t;

  function automatic addr_t bit_rev(addr_t v);
    addr_t r;
    for (int b = 0; b < ADDR_W; b++) begin
      r[b] = v[ADDR_W-1-b];
    end
    return r;
  endfunction

  function automatic data_t sat_data(logic signed [VAL_W-1:0] v);
    logic signed [VAL_W-1:0] hi;
    logic signed [VAL_W-1:0] lo;
    hi = VAL_W'({1'b0, {(DATA_WIDTH-1){1'b1}}});
    lo = -hi - VAL_W'(1);
    if (v > hi) return data_t'(hi);
    if (v < lo) return data_t'(lo);
    return data_t'(v);
  endfunction

  // Restoring shift-and-subtract division, used only while building the table.
  function automatic longint unsigned udiv(longint unsigned x, longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], x[i]};
      q = {q[62:0], 1'b0};
      if (r >= d) begin
        r    = r - d;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  // Taylor series in Q30, evaluated at elaboration only.
  function automatic longint taylor_q30(longint unsigned t, bit odd);
    longint unsigned t2;
    longint unsigned term;
    longint unsigned d;
    longint sum;
    t2   = (t * t) >> 30;
    term = odd ? t : (64'd1 << 30);
    sum  = longint'(term);
    for (int n = 1; n <= 12; n++) begin
      d = odd ? longint'(2 * n) * longint'(2 * n + 1) : longint'(2 * n - 1) * longint'(2 * n);
      term = udiv((term * t2) >> 30, d);
      if (n[0]) sum = sum - longint'(term);
      else      sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    if (sum > (longint'(1) << 30)) sum = longint'(1) << 30;
    return sum;
  endfunction

  function automatic longint tw_mag(int j, bit odd);
    longint unsigned t;
    int sh;
    sh = 30 - TW_SHIFT;
    t  = (64'd2 * PI_Q30 * longint'(j) + longint'(POINTS / 2)) / POINTS;
    return (taylor_q30(t, odd) + (longint'(1) << (sh - 1))) >>> sh;
  endfunction

  function automatic longint tw_pos(longint m);
    longint hi;
    hi = (longint'(1) << TW_SHIFT) - 1;
    return (m > hi) ? hi : m;
  endfunction

  function automatic tw_arr_t build_cos();
    tw_arr_t r;
    for (int k = 0; k < HALF_POINTS; k++) begin
      if (k <= POINTS / 4) r[k] = TWIDDLE_WIDTH'(tw_pos(tw_mag(k, 1'b0)));
      else                 r[k] = TWIDDLE_WIDTH'(-tw_mag(k - POINTS / 4, 1'b1));
    end
    return r;
  endfunction

  function automatic tw_arr_t build_sin();
    tw_arr_t r;
    for (int k = 0; k < HALF_POINTS; k++) begin
      if (k <= POINTS / 4) r[k] = TWIDDLE_WIDTH'(tw_pos(tw_mag(k, 1'b1)));
      else                 r[k] = TWIDDLE_WIDTH'(tw_pos(tw_mag(k - POINTS / 4, 1'b0)));
    end
    return r;
  endfunction

  localparam tw_arr_t ROM_COS = build_cos();
  localparam tw_arr_t ROM_SIN = build_sin();

endpackage
`default_nettype wire

### hw/rtl/fftr2_ctrl.sv
// Controller of the FFT core: handshakes, load and read counters, butterfly sequencing.
`default_nettype none
`include "assert_macros.svh"
module fftr2_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 op_i,
  input  logic                 inverse_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output fftr2_pkg::cmd_t      cmd_o
);
  import fftr2_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_RDWAIT = 7'b0000010,
    S_BF_RD  = 7'b0000100,
    S_BF_MUL = 7'b0001000,
    S_BF_ADD = 7'b0010000,
    S_BF_WA  = 7'b0100000,
    S_BF_WB  = 7'b1000000
  } state_e;

  state_e                state_q, state_d;
  addr_t                 load_cnt_q, load_cnt_d;
  addr_t                 rd_ptr_q, rd_ptr_d;
  logic                  dir_q, dir_d;
  logic                  ready_q, ready_d;
  logic                  out_valid_q, out_valid_d;
  logic [STAGE_W-1:0]    stage_q, stage_d;
  logic [TW_ADDR_W-1:0]  bf_q, bf_d;

  addr_t hmask, kk, grp, addr_a, addr_b;
  logic  accept, bf_last;

  assign in_ready_o  = (state_q == S_IDLE) && !out_valid_q;
  assign out_valid_o = out_valid_q;
  assign accept      = in_valid_i && in_ready_o;

  // Butterfly addresses for the current stage and butterfly counter.
  assign hmask   = (ADDR_W'(1) << stage_q) - ADDR_W'(1);
  assign kk      = {1'b0, bf_q} & hmask;
  assign grp     = {1'b0, bf_q} >> stage_q;
  assign addr_a  = (grp << (stage_q + STAGE_W'(1))) | kk;
  assign addr_b  = addr_a | (ADDR_W'(1) << stage_q);
  assign bf_last = (bf_q == {TW_ADDR_W{1'b1}}) && (stage_q == STAGE_W'(LOG_POINTS - 1));

  always_comb begin
    state_d     = state_q;
    load_cnt_d  = load_cnt_q;
    rd_ptr_d    = rd_ptr_q;
    dir_d       = dir_q;
    ready_d     = ready_q;
    out_valid_d = out_valid_q;
    stage_d     = stage_q;
    bf_d        = bf_q;

    cmd_o           = '0;
    cmd_o.wr_sel    = WR_LOAD;
    cmd_o.inverse   = dir_q;
    cmd_o.rd_addr_a = rd_ptr_q;
    cmd_o.rd_addr_b = addr_b;
    cmd_o.tw_idx    = TW_ADDR_W'(kk << (STAGE_W'(LOG_POINTS - 1) - stage_q));

    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (accept && !op_i) begin
          cmd_o.wr_en   = 1'b1;
          cmd_o.wr_sel  = WR_LOAD;
          cmd_o.wr_addr = bit_rev(load_cnt_q);
          if (load_cnt_q == '0) begin
            dir_d    = inverse_i;
            ready_d  = 1'b0;
            rd_ptr_d = '0;
          end
          load_cnt_d = load_cnt_q + ADDR_W'(1);
          if (load_cnt_q == {ADDR_W{1'b1}}) begin
            stage_d = '0;
            bf_d    = '0;
            state_d = S_BF_RD;
          end
        end else if (accept && op_i) begin
          if (!ready_q) begin
            cmd_o.out_empty = 1'b1;
            out_valid_d     = 1'b1;
          end else begin
            state_d = S_RDWAIT;
          end
        end
      end
      S_RDWAIT: begin
        cmd_o.out_load = 1'b1;
        out_valid_d    = 1'b1;
        rd_ptr_d       = rd_ptr_q + ADDR_W'(1);
        if (rd_ptr_q == {ADDR_W{1'b1}}) ready_d = 1'b0;
        state_d = S_IDLE;
      end
      S_BF_RD: begin
        cmd_o.rd_addr_a = addr_a;
        state_d         = S_BF_MUL;
      end
      S_BF_MUL: begin
        cmd_o.rd_addr_a = addr_a;
        cmd_o.mul_en    = 1'b1;
        state_d         = S_BF_ADD;
      end
      S_BF_ADD: begin
        cmd_o.rd_addr_a = addr_a;
        cmd_o.add_en    = 1'b1;
        state_d         = S_BF_WA;
      end
      S_BF_WA: begin
        cmd_o.rd_addr_a = addr_a;
        cmd_o.wr_en     = 1'b1;
        cmd_o.wr_sel    = WR_A;
        cmd_o.wr_addr   = addr_a;
        state_d         = S_BF_WB;
      end
      S_BF_WB: begin
        cmd_o.rd_addr_a = addr_a;
        cmd_o.wr_en     = 1'b1;
        cmd_o.wr_sel    = WR_B;
        cmd_o.wr_addr   = addr_b;
        bf_d            = bf_q + TW_ADDR_W'(1);
        if (bf_q == {TW_ADDR_W{1'b1}}) stage_d = stage_q + STAGE_W'(1);
        if (bf_last) begin
          ready_d  = 1'b1;
          rd_ptr_d = '0;
          state_d  = S_IDLE;
        end else begin
          state_d = S_BF_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      load_cnt_q  <= '0;
      rd_ptr_q    <= '0;
      dir_q       <= 1'b0;
      ready_q     <= 1'b0;
      out_valid_q <= 1'b0;
      stage_q     <= '0;
      bf_q        <= '0;
    end else begin
      state_q     <= state_d;
      load_cnt_q  <= load_cnt_d;
      rd_ptr_q    <= rd_ptr_d;
      dir_q       <= dir_d;
      ready_q     <= ready_d;
      out_valid_q <= out_valid_d;
      stage_q     <= stage_d;
      bf_q        <= bf_d;
    end
  end

  `ASSERT_IMP(a_ready_no_pending, in_ready_o, !out_valid_q)
  `ASSERT_IMP(a_wr_in_state, cmd_o.wr_en,
              (state_q == S_IDLE) || (state_q == S_BF_WA) || (state_q == S_BF_WB))
  `ASSERT_NXT(a_frame_done, (state_q == S_BF_WB) && bf_last, ready_q && (state_q == S_IDLE))

endmodule
`default_nettype wire

### hw/rtl/fftr2_dp.sv
// Datapath of the FFT core: sample memory, twiddle table, butterfly and result register.
`default_nettype none
module fftr2_dp (
  input  logic                                clk_i,
  input  fftr2_pkg::cmd_t                     cmd_i,
  input  logic signed [fftr2_pkg::SAMPLE_WIDTH-1:0] sample_re_i,
  input  logic signed [fftr2_pkg::SAMPLE_WIDTH-1:0] sample_im_i,
  output fftr2_pkg::data_t                    bin_re_o,
  output fftr2_pkg::data_t                    bin_im_o,
  output fftr2_pkg::addr_t                    bin_index_o,
  output logic                                last_o,
  output logic                                empty_o
);
  import fftr2_pkg::*;

  logic [2*DATA_WIDTH-1:0] mem_q [POINTS];
  logic [2*DATA_WIDTH-1:0] rda_q, rdb_q, wdata;

  logic signed [PROD_W-1:0] brc_q, bis_q, bic_q, brs_q;
  data_t res_ar_q, res_ai_q, res_br_q, res_bi_q;
  data_t out_re_q, out_im_q;
  addr_t out_idx_q;
  logic  out_last_q, out_empty_q;

  data_t ar, ai, br, bi;
  tw_t   tw_c, tw_s;
  logic signed [SUM_W-1:0] pr, pi;
  logic signed [VAL_W-1:0] vr, vi;
  logic signed [DATA_WIDTH:0] scl_re, scl_im;

  assign ar   = data_t'(rda_q[DATA_WIDTH-1:0]);
  assign ai   = data_t'(rda_q[2*DATA_WIDTH-1:DATA_WIDTH]);
  assign br   = data_t'(rdb_q[DATA_WIDTH-1:0]);
  assign bi   = data_t'(rdb_q[2*DATA_WIDTH-1:DATA_WIDTH]);
  assign tw_c = ROM_COS[cmd_i.tw_idx];
  assign tw_s = ROM_SIN[cmd_i.tw_idx];

  always_comb begin
    case (cmd_i.wr_sel)
      WR_A:    wdata = {res_ai_q, res_ar_q};
      WR_B:    wdata = {res_bi_q, res_br_q};
      default: wdata = {DATA_WIDTH'(sample_im_i), DATA_WIDTH'(sample_re_i)};
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) mem_q[cmd_i.wr_addr] <= wdata;
    rda_q <= mem_q[cmd_i.rd_addr_a];
    rdb_q <= mem_q[cmd_i.rd_addr_b];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      brc_q <= PROD_W'(br) * PROD_W'(tw_c);
      bis_q <= PROD_W'(bi) * PROD_W'(tw_s);
      bic_q <= PROD_W'(bi) * PROD_W'(tw_c);
      brs_q <= PROD_W'(br) * PROD_W'(tw_s);
    end
  end

  // Twiddle product rounded half up back to data scale.
  always_comb begin
    if (cmd_i.inverse) begin
      pr = SUM_W'(brc_q) - SUM_W'(bis_q);
      pi = SUM_W'(bic_q) + SUM_W'(brs_q);
    end else begin
      pr = SUM_W'(brc_q) + SUM_W'(bis_q);
      pi = SUM_W'(bic_q) - SUM_W'(brs_q);
    end
    vr = VAL_W'((pr + (SUM_W'(1) <<< (TW_SHIFT - 1))) >>> TW_SHIFT);
    vi = VAL_W'((pi + (SUM_W'(1) <<< (TW_SHIFT - 1))) >>> TW_SHIFT);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.add_en) begin
      res_ar_q <= sat_data(VAL_W'(ar) + vr);
      res_ai_q <= sat_data(VAL_W'(ai) + vi);
      res_br_q <= sat_data(VAL_W'(ar) - vr);
      res_bi_q <= sat_data(VAL_W'(ai) - vi);
    end
  end

  // The inverse divides by the point count with rounding when the bin leaves.
  assign scl_re = ((DATA_WIDTH+1)'(ar) + (DATA_WIDTH+1)'(POINTS / 2)) >>> LOG_POINTS;
  assign scl_im = ((DATA_WIDTH+1)'(ai) + (DATA_WIDTH+1)'(POINTS / 2)) >>> LOG_POINTS;

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_re_q    <= cmd_i.inverse ? DATA_WIDTH'(scl_re) : ar;
      out_im_q    <= cmd_i.inverse ? DATA_WIDTH'(scl_im) : ai;
      out_idx_q   <= cmd_i.rd_addr_a;
      out_last_q  <= (cmd_i.rd_addr_a == {ADDR_W{1'b1}});
      out_empty_q <= 1'b0;
    end else if (cmd_i.out_empty) begin
      out_re_q    <= '0;
      out_im_q    <= '0;
      out_idx_q   <= '0;
      out_last_q  <= 1'b0;
      out_empty_q <= 1'b1;
    end
  end

  assign bin_re_o    = out_re_q;
  assign bin_im_o    = out_im_q;
  assign bin_index_o = out_idx_q;
  assign last_o      = out_last_q;
  assign empty_o     = out_empty_q;

endmodule
`default_nettype wire

### hw/rtl/fft_radix2_512_point_core.sv
// Top level of the 512-point radix-2 FFT core.
//
//  channel  | direction | content
//  s_axis   | in        | load one sample or request the next bin
//  m_axis   | out       | one result bin per read request
//
// Loads are taken back to back. The 512th load starts the transform: 9 stages of
// 256 butterflies, each passing the read, multiply, add and two write states on
// the single butterfly unit and memory write port; no transfer is taken meanwhile.
// A read passes a wait state that registers the bin for m_axis, an empty read
// registers its empty result from the idle state; a new transfer is taken only
// after the previous result has left. Reset is asynchronous; the sample memory is not cleared.
`default_nettype none
module fft_radix2_512_point_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // sample_re[15:0], sample_im[31:16]
  input  logic [1:0]  s_axis_tuser,   // op[0], inverse[1]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // bin_re[25:0], bin_im[51:26], bin_index[60:52], zero
  output logic        m_axis_tlast,   // last
  output logic        m_axis_tuser    // empty_res
);
  import fftr2_pkg::*;

  cmd_t  cmd;
  data_t bin_re, bin_im;
  addr_t bin_index;

  fftr2_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .op_i        (s_axis_tuser[0]),
    .inverse_i   (s_axis_tuser[1]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  fftr2_dp u_dp (
    .clk_i       (clk_i),
    .cmd_i       (cmd),
    .sample_re_i (s_axis_tdata[15:0]),
    .sample_im_i (s_axis_tdata[31:16]),
    .bin_re_o    (bin_re),
    .bin_im_o    (bin_im),
    .bin_index_o (bin_index),
    .last_o      (m_axis_tlast),
    .empty_o     (m_axis_tuser)
  );

  assign m_axis_tdata = {3'b000, bin_index, bin_im, bin_re};

endmodule
`default_nettype wire

### tb/sv/tb.sv
// Self-checking testbench for the 512-point radix-2 FFT core.
`timescale 1ns / 1ps
`default_nettype none
module tb;
  import fftr2_pkg::*;

  typedef enum bit {OP_LOAD = 1'b0, OP_READ = 1'b1} op_e;

  typedef struct {
    op_e                      op;
    logic signed [15:0]       re;
    logic signed [15:0]       im;
    bit                       inv;
  } fft_req_t;

  typedef struct packed {
    data_t re;
    data_t im;
    addr_t idx;
    logic  last;
    logic  empty;
  } fft_bin_t;

  // Predicts the bins of the core and checks every result transfer in order.
  class fft_scoreboard;
    longint   re_mem[POINTS];
    longint   im_mem[POINTS];
    longint   cos_tab[HALF_POINTS];
    longint   sin_tab[HALF_POINTS];
    int       fill;
    int       rd_ptr;
    bit       inv_dir;
    bit       frame_done;
    fft_bin_t bins_q[$];
    int       mism;
    int       checked;
    int       frames;

    function new();
      longint unsigned t;
      longint cm, sm;
      int j;
      for (int k = 0; k < HALF_POINTS; k++) begin
        j  = (k <= POINTS / 4) ? k : k - POINTS / 4;
        t  = (64'd2 * PI_Q30 * longint'(j) + POINTS / 2) / POINTS;
        cm = (series_q30(t, 1'b0) + 4096) >>> 13;
        sm = (series_q30(t, 1'b1) + 4096) >>> 13;
        if (k <= POINTS / 4) begin
          cos_tab[k] = (cm > 131071) ? 131071 : cm;
          sin_tab[k] = (sm > 131071) ? 131071 : sm;
        end else begin
          cos_tab[k] = -sm;
          sin_tab[k] = (cm > 131071) ? 131071 : cm;
        end
      end
    endfunction

    function longint series_q30(longint unsigned t, bit odd);
      longint unsigned t2, term, d;
      longint sum;
      t2   = (t * t) >> 30;
      term = odd ? t : (64'd1 << 30);
      sum  = longint'(term);
      for (int n = 1; n <= 12; n++) begin
        d    = odd ? (2 * n) * (2 * n + 1) : (2 * n - 1) * (2 * n);
        term = ((term * t2) >> 30) / d;
        sum  = (n % 2 == 1) ? sum - longint'(term) : sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      if (sum > (longint'(1) << 30)) sum = longint'(1) << 30;
      return sum;
    endfunction

    function longint clip(longint v);
      return (v > 33554431) ? 33554431 : ((v < -33554432) ? -33554432 : v);
    endfunction

    function void transform();
      int r, w;
      longint tmp, c, s, br, bi, vr, vi, ar, ai;
      for (int i = 0; i < POINTS; i++) begin
        r = 0;
        for (int b = 0; b < LOG_POINTS; b++) r = (r << 1) | ((i >> b) & 1);
        if (i < r) begin
          tmp = re_mem[i]; re_mem[i] = re_mem[r]; re_mem[r] = tmp;
          tmp = im_mem[i]; im_mem[i] = im_mem[r]; im_mem[r] = tmp;
        end
      end
      for (int span = 2; span <= POINTS; span *= 2) begin
        for (int i = 0; i < POINTS; i += span) begin
          for (int k = 0; k < span / 2; k++) begin
            w  = (k * (POINTS / span)) % HALF_POINTS;
            c  = cos_tab[w];
            s  = sin_tab[w];
            br = re_mem[i + k + span / 2];
            bi = im_mem[i + k + span / 2];
            // The inverse direction uses the conjugate twiddle.
            if (inv_dir) begin
              vr = (br * c - bi * s + 65536) >>> 17;
              vi = (bi * c + br * s + 65536) >>> 17;
            end else begin
              vr = (br * c + bi * s + 65536) >>> 17;
              vi = (bi * c - br * s + 65536) >>> 17;
            end
            ar = re_mem[i + k];
            ai = im_mem[i + k];
            re_mem[i + k] = clip(ar + vr);
            im_mem[i + k] = clip(ai + vi);
            re_mem[i + k + span / 2] = clip(ar - vr);
            im_mem[i + k + span / 2] = clip(ai - vi);
          end
        end
      end
      if (inv_dir) begin
        for (int i = 0; i < POINTS; i++) begin
          re_mem[i] = clip((re_mem[i] + POINTS / 2) >>> LOG_POINTS);
          im_mem[i] = clip((im_mem[i] + POINTS / 2) >>> LOG_POINTS);
        end
      end
    endfunction

    function void note_input(fft_req_t req);
      fft_bin_t b;
      if (req.op == OP_LOAD) begin
        if (fill == 0) begin
          inv_dir    = req.inv;
          frame_done = 0;
          rd_ptr     = 0;
        end
        re_mem[fill] = req.re;
        im_mem[fill] = req.im;
        fill++;
        if (fill == POINTS) begin
          fill = 0;
          transform();
          frame_done = 1;
          rd_ptr     = 0;
          frames++;
        end
      end else if (!frame_done) begin
        b = '{re: '0, im: '0, idx: '0, last: 1'b0, empty: 1'b1};
        bins_q.push_back(b);
      end else begin
        b = '{re: data_t'(re_mem[rd_ptr]), im: data_t'(im_mem[rd_ptr]),
              idx: addr_t'(rd_ptr), last: rd_ptr == POINTS - 1, empty: 1'b0};
        bins_q.push_back(b);
        rd_ptr++;
        if (rd_ptr == POINTS) begin
          rd_ptr     = 0;
          frame_done = 0;
        end
      end
    endfunction

    function void check_result(fft_bin_t got);
      fft_bin_t exp_bin;
      checked++;
      if (bins_q.size() == 0) begin
        mism++;
        if (mism <= 10) $display("unexpected result transfer: idx %0d", got.idx);
        return;
      end
      exp_bin = bins_q.pop_front();
      if (got != exp_bin) begin
        mism++;
        if (mism <= 10)
          $display("bin mismatch: exp re %0d im %0d idx %0d last %0b empty %0b, %s",
                   exp_bin.re, exp_bin.im, exp_bin.idx, exp_bin.last, exp_bin.empty,
                   $sformatf("got re %0d im %0d idx %0d last %0b empty %0b",
                             got.re, got.im, got.idx, got.last, got.empty));
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic        m_tlast;
  logic        m_tuser;

  fft_scoreboard bins_sb = new();
  fft_req_t      stim_q[$];
  int            sent;
  int            cyc;
  int            hold;
  bit            held;

  fft_radix2_512_point_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tlast  (m_tlast),
    .m_axis_tuser  (m_tuser)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Quiet window over most of the sample load: neither side idles here.
  function automatic bit idle_now();
    return !(cyc >= 100 && cyc < 600) && ($urandom_range(99) < 19);
  endfunction

  always @(posedge clk_i) begin
    cyc++;
    if (rst_ni) begin
      if (s_tvalid && s_tready) begin
        bins_sb.note_input(stim_q[sent]);
        sent++;
      end
      if (!(s_tvalid && !s_tready)) begin
        if (sent < stim_q.size() && !idle_now()) begin
          s_tdata  <= {stim_q[sent].im, stim_q[sent].re};
          s_tuser  <= {stim_q[sent].inv, stim_q[sent].op};
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_tvalid && m_tready)
        bins_sb.check_result('{re: m_tdata[25:0], im: m_tdata[51:26],
                               idx: m_tdata[60:52], last: m_tlast, empty: m_tuser});
      // One long hold-off lets the sender run into back-pressure.
      if (!held && bins_sb.checked == 150) begin
        held = 1;
        hold = 4000;
      end
      if (hold > 0) begin
        hold--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= !idle_now();
      end
    end
  end

  initial begin
    fft_req_t req;
    bit       frame_dir;
    frame_dir = 1'($urandom);
    // Reads before any frame exists come back empty.
    repeat (3) stim_q.push_back('{op: OP_READ, re: 0, im: 0, inv: 0});
    // One frame with full-scale samples mixed in. Only the first load sets the
    // direction, and reads mixed into the load find no finished frame.
    for (int i = 0; i < POINTS; i++) begin
      if ($urandom_range(99) < 4)
        stim_q.push_back('{op: OP_READ, re: 16'($urandom), im: 16'($urandom),
                           inv: 1'($urandom)});
      req.op  = OP_LOAD;
      req.re  = ($urandom_range(9) == 0) ? (i[0] ? 16'sh7fff : 16'sh8000) : 16'($urandom);
      req.im  = ($urandom_range(9) == 0) ? 16'sh7fff : 16'($urandom);
      req.inv = (i == 0) ? frame_dir : 1'($urandom);
      stim_q.push_back(req);
    end
    // Read part of the frame; the loads of a new frame then discard the rest.
    repeat (260)
      stim_q.push_back('{op: OP_READ, re: 16'($urandom), im: 16'($urandom),
                         inv: 1'($urandom)});
    repeat (4) begin
      req.op  = OP_LOAD;
      req.re  = 16'($urandom);
      req.im  = 16'($urandom);
      req.inv = 1'($urandom);
      stim_q.push_back(req);
    end
    repeat (2) stim_q.push_back('{op: OP_READ, re: 0, im: 0, inv: 0});
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (!(sent == stim_q.size() && bins_sb.bins_q.size() == 0)) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    $display("Sent %0d items: %0d %s transform(s), empty reads and a partly read frame",
             sent, bins_sb.frames, frame_dir ? "inverse" : "forward");
    $display("discarded by new loads; checked %0d result transfers.", bins_sb.checked);
    if (bins_sb.mism == 0 && bins_sb.bins_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", bins_sb.mism);
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout");
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
`default_nettype wire

### files.f
+incdir+hw/rtl
hw/rtl/fftr2_pkg.sv
hw/rtl/fftr2_ctrl.sv
hw/rtl/fftr2_dp.sv
hw/rtl/fft_radix2_512_point_core.sv
tb/sv/tb.sv
